FILE: design/smalu_pkg.sv
package smalu_pkg;

	localparam int WORD_W = 16;
	localparam int MAG_W  = WORD_W - 1;
	localparam int FB_W   = 4;
	localparam int FB_MAX = (1 << FB_W) - 1;
	localparam int FN_W   = 3;

	// Dividend is |a| << frac_bits, padded up to a whole number of stages.
	localparam int DIV_W      = MAG_W + FB_MAX;
	localparam int BPS        = 3;
	localparam int DIV_STAGES = (DIV_W + BPS - 1) / BPS;
	localparam int DVD_W      = DIV_STAGES * BPS;

	localparam logic [FB_W-1:0] FB_RESET = FB_W'(8);

	localparam logic [FN_W-1:0] FN_ADD = 3'd0;
	localparam logic [FN_W-1:0] FN_SUB = 3'd1;
	localparam logic [FN_W-1:0] FN_MUL = 3'd2;
	localparam logic [FN_W-1:0] FN_DIV = 3'd3;
	localparam logic [FN_W-1:0] FN_ABS = 3'd4;

	typedef struct packed {
		logic [FN_W-1:0]   func;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [DVD_W-1:0] dvd;
		logic [MAG_W-1:0] quo;
		logic [MAG_W-1:0] mb;
	} div_t;

	typedef struct packed {
		logic [FN_W-1:0]   func;
		logic              sign;
		logic              dz;
		logic [WORD_W-1:0] res;
	} side_t;

endpackage

FILE: design/smalu_div_stage.sv
module smalu_div_stage (
	input  logic               clk,
	input  logic               ld,
	input  smalu_pkg::div_t    d_in,
	output smalu_pkg::div_t    d_out
);
	import smalu_pkg::*;

	div_t           work;
	logic [MAG_W:0] trial;
	div_t           div_s1;

	// Restoring division, BPS quotient bits per stage.
	always_comb begin
		work  = d_in;
		trial = '0;
		for (int i = 0; i < BPS; i++) begin
			trial    = {work.rem, work.dvd[DVD_W-1]};
			work.dvd = {work.dvd[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, work.mb}) begin
				work.rem = MAG_W'(trial - {1'b0, work.mb});
				work.quo = {work.quo[MAG_W-2:0], 1'b1};
			end else begin
				work.rem = trial[MAG_W-1:0];
				work.quo = {work.quo[MAG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			div_s1 <= work;
		end
	end

	assign d_out = div_s1;

endmodule

FILE: design/sign_magnitude_fixed_point_alu_unit.sv
// Sign-magnitude fixed-point ALU: add, subtract, multiply, divide, absolute value.
//
// Request channel: req_valid / req_stall / req_data (func, operand_a, operand_b).
// A request is taken at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall / rsp_data (result, divide_by_zero),
// taken at an edge with rsp_valid high and rsp_stall low.
// Configuration: cfg_valid / cfg_ready / cfg_data writes frac_bits; cfg_ready is
// always high. Write it only while no request is in flight.
//
// Throughput: one request per cycle while the response is not stalled. Every
// request passes all 3 + DIV_STAGES register stages before its response is valid
// (two operand stages, ten divider stages, one output register).
// The divider resolves three quotient bits per stage; that sets the depth.
//
// A stalled response holds in the output register; bubbles in the pipeline
// still fill, and req_stall rises only when every stage is occupied.
// Reset empties the pipeline and sets frac_bits to 8.
module sign_magnitude_fixed_point_alu_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  smalu_pkg::req_t           req_data,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output smalu_pkg::rsp_t           rsp_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [smalu_pkg::FB_W-1:0] cfg_data
);
	import smalu_pkg::*;

	logic [FB_W-1:0] frac_q;

	// stage 1: operand capture
	logic            v_s1;
	logic [FN_W-1:0] func_s1;
	logic            sa_s1, sb_s1;
	logic [MAG_W-1:0] ma_s1, mb_s1;
	logic [FB_W-1:0] fb_s1;

	// stage 2: add result, product, divider setup
	logic              v_s2;
	side_t             side_s2;
	logic [2*MAG_W-1:0] prod_s2;
	logic [FB_W-1:0]   fb_s2;
	div_t              div_s2;

	// divider stages
	logic  vd_s   [DIV_STAGES];
	side_t side_s [DIV_STAGES];
	div_t  div_in [DIV_STAGES];
	div_t  div_out[DIV_STAGES];
	side_t side_in[DIV_STAGES];
	logic  ld_d   [DIV_STAGES];

	// output register
	logic v_sout;
	rsp_t res_sout;

	logic ld_1, ld_2, ld_o;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= FB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frac_q <= cfg_data;
		end
	end

	// A stage loads when empty or when its content moves on.
	always_comb begin
		ld_o = !v_sout || !rsp_stall;
		ld_d[DIV_STAGES-1] = !vd_s[DIV_STAGES-1] || ld_o;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			ld_d[k] = !vd_s[k] || ld_d[k+1];
		end
		ld_2 = !v_s2 || ld_d[0];
		ld_1 = !v_s1 || ld_2;
	end

	assign req_stall = !ld_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_1) begin
			func_s1 <= req_data.func;
			sa_s1   <= req_data.operand_a[WORD_W-1];
			sb_s1   <= req_data.operand_b[WORD_W-1];
			ma_s1   <= req_data.operand_a[MAG_W-1:0];
			mb_s1   <= req_data.operand_b[MAG_W-1:0];
			fb_s1   <= frac_q;
		end
	end

	// Add and subtract on magnitudes; subtract flips the sign of b.
	logic              sbe;
	logic [WORD_W-1:0] add_res;
	side_t             side_nxt;
	div_t              div_nxt;

	always_comb begin
		sbe = (func_s1 == FN_SUB) ? !sb_s1 : sb_s1;
		if (sa_s1 == sbe) begin
			add_res = {sa_s1, MAG_W'(ma_s1 + mb_s1)};
		end else if (ma_s1 > mb_s1) begin
			add_res = {sa_s1, MAG_W'(ma_s1 - mb_s1)};
		end else if (mb_s1 > ma_s1) begin
			add_res = {sbe, MAG_W'(mb_s1 - ma_s1)};
		end else begin
			add_res = '0;
		end

		side_nxt.func = func_s1;
		side_nxt.sign = sa_s1 ^ sb_s1;
		side_nxt.dz   = (func_s1 == FN_DIV) && (mb_s1 == '0);
		case (func_s1)
			FN_ADD, FN_SUB: side_nxt.res = add_res;
			FN_ABS:         side_nxt.res = {1'b0, ma_s1};
			default:        side_nxt.res = '0;
		endcase

		div_nxt.rem = '0;
		div_nxt.quo = '0;
		div_nxt.mb  = mb_s1;
		div_nxt.dvd = {{(DVD_W-MAG_W){1'b0}}, ma_s1} << fb_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_2) begin
			side_s2 <= side_nxt;
			prod_s2 <= (2*MAG_W)'(ma_s1) * (2*MAG_W)'(mb_s1);
			fb_s2   <= fb_s1;
			div_s2  <= div_nxt;
		end
	end

	// Finish the multiply on entry to the divider stages.
	always_comb begin
		side_in[0] = side_s2;
		if (side_s2.func == FN_MUL) begin
			side_in[0].res = {side_s2.sign, MAG_W'(prod_s2 >> fb_s2)};
		end
		div_in[0] = div_s2;
		for (int k = 1; k < DIV_STAGES; k++) begin
			side_in[k] = side_s[k-1];
			div_in[k]  = div_out[k-1];
		end
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		smalu_div_stage u_stage (
			.clk   (clk),
			.ld    (ld_d[g]),
			.d_in  (div_in[g]),
			.d_out (div_out[g])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[g] <= 1'b0;
			end else if (ld_d[g]) begin
				vd_s[g] <= (g == 0) ? v_s2 : vd_s[(g == 0) ? 0 : g - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (ld_d[g]) begin
				side_s[g] <= side_in[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sout <= 1'b0;
		end else if (ld_o) begin
			v_sout <= vd_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_o) begin
			if (side_s[DIV_STAGES-1].func == FN_DIV) begin
				res_sout.result <= {side_s[DIV_STAGES-1].sign, div_out[DIV_STAGES-1].quo};
			end else begin
				res_sout.result <= side_s[DIV_STAGES-1].res;
			end
			res_sout.divide_by_zero <= side_s[DIV_STAGES-1].dz;
		end
	end

	assign rsp_valid = v_sout;
	assign rsp_data  = res_sout;

	// A zero divisor drives the quotient to all ones.
	a_dz_mag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result[MAG_W-1:0] == '1)
		else $error("divide by zero without saturated magnitude");

	// Input backs up only when the response is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with room downstream");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> v_s1)
		else $error("accepted request lost at stage 1");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(vd_s[DIV_STAGES-1]))
		else $error("response appeared without a divider stage feeding it");

endmodule

FILE: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smalu_pkg::*;

	localparam logic [FN_W-1:0] FN_LAST = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int PIPE_DEPTH = 3 + DIV_STAGES;
	localparam int PRINT_CAP = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FB_W-1:0] cfg_data = '0;

	sign_magnitude_fixed_point_alu_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	logic [FB_W-1:0] cur_frac = FB_RESET;
	rsp_t pending_rsp[$];
	req_t pending_req[$];
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int errors = 0;
	int idle_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] sm_add(logic sa, logic [MAG_W-1:0] ma,
			logic sb, logic [MAG_W-1:0] mb);
		logic [MAG_W-1:0] sum;
		sum = ma + mb;
		if (sa == sb)
			return {sa, sum};
		if (ma > mb)
			return {sa, MAG_W'(ma - mb)};
		if (mb > ma)
			return {sb, MAG_W'(mb - ma)};
		return '0;
	endfunction

	function automatic rsp_t alu_predict(req_t r, logic [FB_W-1:0] fb);
		rsp_t o;
		logic sa, sb;
		logic [MAG_W-1:0] ma, mb;
		logic [63:0] wide;
		sa = r.operand_a[WORD_W-1];
		sb = r.operand_b[WORD_W-1];
		ma = r.operand_a[MAG_W-1:0];
		mb = r.operand_b[MAG_W-1:0];
		o = '0;
		case (r.func)
			FN_ADD: o.result = sm_add(sa, ma, sb, mb);
			FN_SUB: o.result = sm_add(sa, ma, ~sb, mb);
			FN_MUL: begin
				wide = (64'(ma) * 64'(mb)) >> fb;
				o.result = {sa ^ sb, wide[MAG_W-1:0]};
			end
			FN_DIV: begin
				if (mb == '0) begin
					o.divide_by_zero = 1'b1;
					o.result = {sa ^ sb, {MAG_W{1'b1}}};
				end else begin
					wide = (64'(ma) << fb) / 64'(mb);
					o.result = {sa ^ sb, wide[MAG_W-1:0]};
				end
			end
			FN_ABS: o.result = {1'b0, ma};
			default: o = '0;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Response checker: compare each taken response with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		req_t src;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response %h", rsp_data));
			end else begin
				want = pending_rsp.pop_front();
				src = pending_req.pop_front();
				if (rsp_data.result !== want.result)
					report_mismatch($sformatf("func %0d a %h b %h frac %0d: result %h want %h",
						src.func, src.operand_a, src.operand_b, cur_frac,
						rsp_data.result, want.result));
				if (rsp_data.divide_by_zero !== want.divide_by_zero)
					report_mismatch($sformatf("func %0d a %h b %h: divide_by_zero %b want %b",
						src.func, src.operand_a, src.operand_b,
						rsp_data.divide_by_zero, want.divide_by_zero));
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic send_req(input logic [FN_W-1:0] fn, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		req_t r;
		r.func = fn;
		r.operand_a = a;
		r.operand_b = b;
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(alu_predict(r, cur_frac));
		pending_req.push_back(r);
	endtask

	task automatic hold_until_drained(input int extra);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_frac(input logic [FB_W-1:0] v);
		hold_until_drained(2);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_frac = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		logic s;
		s = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: return {s, {MAG_W{1'b0}}};
			1: return {s, {MAG_W{1'b1}}};
			2: return {s, MAG_W'($urandom_range(15))};
			3: return {s, MAG_W'($urandom_range(1023))};
			default: return WORD_W'($urandom);
		endcase
	endfunction

	task automatic send_random();
		logic [FN_W-1:0] fn;
		logic [WORD_W-1:0] a, b;
		int pick;
		pick = $urandom_range(19);
		if (pick >= 18)
			fn = FN_W'($urandom_range(FN_LAST, FN_ABS + 1));
		else
			fn = FN_W'(pick % 5);
		a = pick_word();
		if ($urandom_range(5) == 0)
			b = {1'($urandom_range(1)), a[MAG_W-1:0]};
		else
			b = pick_word();
		send_req(fn, a, b);
	endtask

	task automatic test_directed();
		logic [FN_W-1:0] fn;
		send_req(FN_ADD, 16'h7fff, 16'h7fff);
		send_req(FN_ADD, 16'h8000, 16'h8000);
		send_req(FN_ADD, 16'h1234, 16'h9234);
		send_req(FN_ADD, 16'h9000, 16'h0123);
		send_req(FN_ADD, 16'h0005, 16'hf000);
		send_req(FN_SUB, 16'h0005, 16'h0005);
		send_req(FN_SUB, 16'h7fff, 16'hffff);
		send_req(FN_SUB, 16'h8001, 16'h0002);
		send_req(FN_MUL, 16'h7fff, 16'h7fff);
		send_req(FN_MUL, 16'hffff, 16'hffff);
		send_req(FN_MUL, 16'h8000, 16'h0003);
		send_req(FN_MUL, 16'h0100, 16'h8100);
		send_req(FN_DIV, 16'h1234, 16'h8000);
		send_req(FN_DIV, 16'h0000, 16'h0000);
		send_req(FN_DIV, 16'hffff, 16'h0001);
		send_req(FN_DIV, 16'h0000, 16'h8005);
		send_req(FN_DIV, 16'h0001, 16'h7fff);
		send_req(FN_ABS, 16'hffff, 16'h1234);
		send_req(FN_ABS, 16'h8000, 16'hffff);
		send_req(FN_ABS, 16'h7fff, 16'h0000);
		for (fn = FN_W'(FN_ABS + 1); fn != '0; fn++)
			send_req(fn, 16'hffff, 16'hffff);
	endtask

	// Fractional-bit extremes: zero, fourteen and the maximum, FB_MAX.
	task automatic test_frac_extremes();
		logic [FB_W-1:0] fbs[3];
		fbs = '{FB_W'(0), FB_W'(14), FB_W'(FB_MAX)};
		foreach (fbs[i]) begin
			write_frac(fbs[i]);
			send_req(FN_MUL, 16'h7fff, 16'hffff);
			send_req(FN_DIV, 16'hffff, 16'h0001);
			send_req(FN_DIV, 16'h0001, 16'h7fff);
			send_req(FN_DIV, 16'h8003, 16'h8000);
			repeat (8) send_random();
		end
	endtask

	task automatic test_pressure();
		repeat (16) send_random();
		hold_until_drained(0);
		repeat (16) send_random();
	endtask

	task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
			input int chunks);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (chunks) begin
			write_frac(FB_W'($urandom_range(FB_MAX)));
			repeat (50) send_random();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 23;
		rx_idle_pct = 60;
		test_directed();
		test_frac_extremes();
		test_pressure();
		test_random(23, 60, 5);
		test_random(60, 23, 5);
		test_random(0, 0, 4);
		write_frac(FB_RESET);
		repeat (40) send_random();
		hold_until_drained(PIPE_DEPTH + 4);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
design/smalu_pkg.sv
design/smalu_div_stage.sv
design/sign_magnitude_fixed_point_alu_unit.sv
test/tb.sv
